// ===== rtl/ppmfg_pkg.sv =====
package ppmfg_pkg;

    // Field widths fixed by the stream format
    localparam int CHAN_IDX_W = 4;
    localparam int WIDTH_W    = 15;
    localparam int COUNT_W    = 5;
    localparam int TICK_W     = 17;
    localparam int CFG_ADDR_W = 3;
    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 8;

    localparam int MAX_CHANNELS_DEF = 16;

    // Reset values
    localparam logic [WIDTH_W-1:0] RESET_WIDTH_US = 15'd1500;
    localparam logic [COUNT_W-1:0] RESET_COUNT    = 5'd8;
    localparam logic [WIDTH_W-1:0] RESET_PULSE_US = 15'd250;
    localparam logic [WIDTH_W-1:0] RESET_PAUSE_US = 15'd5250;
    localparam logic [TICK_W-1:0]  RESET_TICKS    = 17'd500;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_CHANNEL_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_LENGTH  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PAUSE_LENGTH  = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT        = 3'd3;

    // Input beat kinds
    localparam logic ACT_TICK  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    // Result of one accepted beat
    typedef struct packed {
        logic level;
        logic frame_start;
    } t_result;

    // Store control from the timer
    typedef struct packed {
        logic                  wr_en;
        logic [CHAN_IDX_W-1:0] wr_idx;
        logic [WIDTH_W-1:0]    wr_data;
        logic                  latch;
    } t_store_ctl;

endpackage

// ===== rtl/ppmfg_store.sv =====
module ppmfg_store #(
    parameter int MAX_CHANNELS = ppmfg_pkg::MAX_CHANNELS_DEF,
    parameter int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ppmfg_pkg::t_store_ctl           i_ctl,
    input  logic [IDX_W-1:0]                i_rd_idx,
    output logic [ppmfg_pkg::WIDTH_W-1:0]   o_rd_data
);

    logic [ppmfg_pkg::WIDTH_W-1:0] r_pending [MAX_CHANNELS];
    logic [ppmfg_pkg::WIDTH_W-1:0] r_frame   [MAX_CHANNELS];
    logic                          wr_hit;

    // Drop writes to channels beyond the store
    assign wr_hit = i_ctl.wr_en && (int'(i_ctl.wr_idx) < MAX_CHANNELS);

    // Pending store takes channel writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_pending[i] <= ppmfg_pkg::RESET_WIDTH_US;
            end
        end else if (wr_hit) begin
            r_pending[IDX_W'(i_ctl.wr_idx)] <= i_ctl.wr_data;
        end
    end

    // Frame store copies the pending store at frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_frame[i] <= ppmfg_pkg::RESET_WIDTH_US;
            end
        end else if (i_ctl.latch) begin
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                r_frame[i] <= r_pending[i];
            end
        end
    end

    assign o_rd_data = r_frame[i_rd_idx];

endmodule

// ===== rtl/ppmfg_timer.sv =====
module ppmfg_timer #(
    parameter int MAX_CHANNELS = ppmfg_pkg::MAX_CHANNELS_DEF,
    parameter int IDX_W        = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [ppmfg_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ppmfg_pkg::WIDTH_W-1:0]       i_cfg_data,
    // accepted input beat
    input  logic                                i_beat,
    input  logic                                i_action,
    input  logic [ppmfg_pkg::CHAN_IDX_W-1:0]    i_chan_idx,
    input  logic [ppmfg_pkg::WIDTH_W-1:0]       i_width_us,
    // frame store access
    output ppmfg_pkg::t_store_ctl               o_store_ctl,
    output logic [IDX_W-1:0]                    o_rd_idx,
    input  logic [ppmfg_pkg::WIDTH_W-1:0]       i_rd_data,
    // result of this beat
    output ppmfg_pkg::t_result                  o_result
);

    localparam int FC_W  = $clog2(MAX_CHANNELS + 1);
    localparam int POS_W = $clog2(2 * (MAX_CHANNELS + 1));
    localparam int TW    = ppmfg_pkg::TICK_W;
    localparam int WW    = ppmfg_pkg::WIDTH_W;

    // configuration registers
    logic [ppmfg_pkg::COUNT_W-1:0] r_cfg_count;
    logic [WW-1:0]                 r_cfg_pulse;
    logic [WW-1:0]                 r_cfg_pause;
    logic                          r_cfg_invert;

    // values latched for the running frame
    logic [FC_W-1:0]  r_frame_count, n_frame_count;
    logic [WW-1:0]    r_frame_pulse, n_frame_pulse;
    logic [WW-1:0]    r_frame_pause, n_frame_pause;

    logic [POS_W-1:0] r_pos, n_pos;
    logic [TW-1:0]    r_ticks, n_ticks;

    logic             tick;
    logic             expire;
    logic [POS_W:0]   pos_inc;
    logic [POS_W:0]   pos_limit;
    logic             wrap;
    logic [FC_W-1:0]  count_clamped;
    logic [WW-1:0]    pulse_src;
    logic [TW-1:0]    pulse_ticks;
    logic [TW-1:0]    width_ticks;
    logic [TW-1:0]    len_ticks;
    logic [POS_W-2:0] gap_idx;
    logic             gap_is_chan;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count  <= ppmfg_pkg::RESET_COUNT;
            r_cfg_pulse  <= ppmfg_pkg::RESET_PULSE_US;
            r_cfg_pause  <= ppmfg_pkg::RESET_PAUSE_US;
            r_cfg_invert <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                ppmfg_pkg::REG_CHANNEL_COUNT: r_cfg_count  <= i_cfg_data[ppmfg_pkg::COUNT_W-1:0];
                ppmfg_pkg::REG_PULSE_LENGTH:  r_cfg_pulse  <= i_cfg_data;
                ppmfg_pkg::REG_PAUSE_LENGTH:  r_cfg_pause  <= i_cfg_data;
                ppmfg_pkg::REG_INVERT:        r_cfg_invert <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamp the channel count into 1..MAX_CHANNELS
    always_comb begin
        if (r_cfg_count == '0) begin
            count_clamped = FC_W'(1);
        end else if (int'(r_cfg_count) > MAX_CHANNELS) begin
            count_clamped = FC_W'(MAX_CHANNELS);
        end else begin
            count_clamped = FC_W'(r_cfg_count);
        end
    end

    assign tick    = i_beat && (i_action == ppmfg_pkg::ACT_TICK);
    assign expire  = (r_ticks <= TW'(1));
    assign pos_inc = {1'b0, r_pos} + (POS_W+1)'(1);
    assign pos_limit = (POS_W+1)'({r_frame_count, 1'b0}) + (POS_W+1)'(2);
    assign wrap    = pos_inc >= pos_limit;

    // Next position; wrap to the first pulse past the pause gap
    assign n_pos = wrap ? '0 : pos_inc[POS_W-1:0];

    // Length of the interval that starts at n_pos
    assign gap_idx     = n_pos[POS_W-1:1];
    assign gap_is_chan = ({1'b0, gap_idx} < POS_W'(r_frame_count));
    assign o_rd_idx    = IDX_W'(gap_idx);
    assign pulse_src   = wrap ? r_cfg_pulse : r_frame_pulse;
    assign pulse_ticks = TW'({pulse_src, 1'b0});
    assign width_ticks = gap_is_chan ? TW'({i_rd_data, 1'b0}) : TW'({r_frame_pause, 1'b0});

    always_comb begin
        if (n_pos[0] == 1'b0) begin
            len_ticks = (pulse_ticks == '0) ? TW'(1) : pulse_ticks;
        end else begin
            // short gap saturates to one tick
            len_ticks = (width_ticks > pulse_ticks) ? (width_ticks - pulse_ticks) : TW'(1);
        end
    end

    // Frame latch values
    assign n_frame_count = count_clamped;
    assign n_frame_pulse = r_cfg_pulse;
    assign n_frame_pause = r_cfg_pause;

    assign n_ticks = expire ? len_ticks : (r_ticks - TW'(1));

    // Advance the timer on every tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= '0;
            r_ticks       <= ppmfg_pkg::RESET_TICKS;
            r_frame_count <= (int'(ppmfg_pkg::RESET_COUNT) > MAX_CHANNELS) ?
                             FC_W'(MAX_CHANNELS) : FC_W'(ppmfg_pkg::RESET_COUNT);
            r_frame_pulse <= ppmfg_pkg::RESET_PULSE_US;
            r_frame_pause <= ppmfg_pkg::RESET_PAUSE_US;
        end else if (tick) begin
            r_ticks <= n_ticks;
            if (expire) begin
                r_pos <= n_pos;
                if (wrap) begin
                    r_frame_count <= n_frame_count;
                    r_frame_pulse <= n_frame_pulse;
                    r_frame_pause <= n_frame_pause;
                end
            end
        end
    end

    // Store control
    assign o_store_ctl.wr_en   = i_beat && (i_action == ppmfg_pkg::ACT_WRITE);
    assign o_store_ctl.wr_idx  = i_chan_idx;
    assign o_store_ctl.wr_data = i_width_us;
    assign o_store_ctl.latch   = tick && expire && wrap;

    // Level after this beat: pulses sit at even positions
    always_comb begin
        if (tick && expire) begin
            o_result.level = ~n_pos[0] ^ r_cfg_invert;
        end else begin
            o_result.level = ~r_pos[0] ^ r_cfg_invert;
        end
        o_result.frame_start = tick && expire && wrap;
    end

endmodule

// ===== rtl/ppmfg_out.sv =====
module ppmfg_out (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  ppmfg_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_free,
    output ppmfg_pkg::t_result o_result
);

    logic               r_valid;
    ppmfg_pkg::t_result r_result;

    // Register free when empty or being drained this cycle
    assign o_free = !r_valid || i_ready;

    // Hold the result until the downstream side takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/ppm_frame_generator.sv =====
// Channel   Direction  Handshake                        Payload
// s_axis    in         s_axis_tvalid / s_axis_tready    tdata, tuser
// m_axis    out        m_axis_tvalid / m_axis_tready    tdata, tuser
// cfg       in         i_cfg_valid / o_cfg_ready        i_cfg_addr, i_cfg_data
//
// One beat per cycle: each beat updates the timer and stores at the edge it is
// taken, its result is registered at that same edge and offered on m_axis from
// the next cycle. Reset (synchronous, active low) loads register defaults and
// all widths to 1500 us; no clearing pass is needed. A stalled output stops
// input only while the output register is full and not being drained.
module ppm_frame_generator #(
    parameter int MAX_CHANNELS = ppmfg_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // [3:0] channel_index, [18:4] channel_width_us, [23:19] zero
    input  logic [ppmfg_pkg::S_TDATA_W-1:0]     s_axis_tdata,
    // [0] action
    input  logic                                s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [0] ppm_level, [7:1] zero
    output logic [ppmfg_pkg::M_TDATA_W-1:0]     m_axis_tdata,
    // [0] frame_start
    output logic                                m_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [ppmfg_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [ppmfg_pkg::WIDTH_W-1:0]       i_cfg_data
);

    localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic                          beat;
    logic                          out_free;
    ppmfg_pkg::t_store_ctl         store_ctl;
    logic [IDX_W-1:0]              rd_idx;
    logic [ppmfg_pkg::WIDTH_W-1:0] rd_data;
    ppmfg_pkg::t_result            result;
    ppmfg_pkg::t_result            out_result;

    assign s_axis_tready = out_free;
    assign beat          = s_axis_tvalid && out_free;
    assign o_cfg_ready   = 1'b1;

    ppmfg_timer #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_beat      (beat),
        .i_action    (s_axis_tuser),
        .i_chan_idx  (s_axis_tdata[3:0]),
        .i_width_us  (s_axis_tdata[18:4]),
        .o_store_ctl (store_ctl),
        .o_rd_idx    (rd_idx),
        .i_rd_data   (rd_data),
        .o_result    (result)
    );

    ppmfg_store #(
        .MAX_CHANNELS (MAX_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (store_ctl),
        .i_rd_idx  (rd_idx),
        .o_rd_data (rd_data)
    );

    ppmfg_out u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (beat),
        .i_result (result),
        .i_ready  (m_axis_tready),
        .o_valid  (m_axis_tvalid),
        .o_free   (out_free),
        .o_result (out_result)
    );

    assign m_axis_tdata = {{(ppmfg_pkg::M_TDATA_W-1){1'b0}}, out_result.level};
    assign m_axis_tuser = out_result.frame_start;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int NCH           = ppmfg_pkg::MAX_CHANNELS_DEF;
    localparam int CLK_HALF      = 6;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_START    = 1000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SMALL_W_MAX   = 10;
    localparam int FULL_W_MAX    = (1 << ppmfg_pkg::WIDTH_W) - 1;
    localparam int REG_MAX_US    = 32766;
    localparam int DRAIN_TICKS   = 300;
    localparam int PHASE_BEATS   = 150;
    localparam int TAIL_TICKS    = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 10;
    localparam int S_PAD_W       = ppmfg_pkg::S_TDATA_W - ppmfg_pkg::CHAN_IDX_W
                                   - ppmfg_pkg::WIDTH_W;

    typedef struct packed {
        logic                             action;
        logic [ppmfg_pkg::CHAN_IDX_W-1:0] idx;
        logic [ppmfg_pkg::WIDTH_W-1:0]    width_us;
    } t_ppm_beat;

    typedef enum logic [2:0] {
        RX_STEADY = 3'b001,
        RX_LIGHT  = 3'b010,
        RX_HEAVY  = 3'b100
    } t_rx_mode;

    logic                               i_clk         = 1'b0;
    logic                               i_rst_n       = 1'b0;
    logic [ppmfg_pkg::S_TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                               s_axis_tuser  = 1'b0;
    logic                               s_axis_tvalid = 1'b0;
    logic                               s_axis_tready;
    logic [ppmfg_pkg::M_TDATA_W-1:0]    m_axis_tdata;
    logic                               m_axis_tuser;
    logic                               m_axis_tvalid;
    logic                               m_axis_tready = 1'b0;
    logic                               i_cfg_valid   = 1'b0;
    logic                               o_cfg_ready;
    logic [ppmfg_pkg::CFG_ADDR_W-1:0]   i_cfg_addr    = '0;
    logic [ppmfg_pkg::WIDTH_W-1:0]      i_cfg_data    = '0;

    ppm_frame_generator #(
        .MAX_CHANNELS(NCH)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data)
    );

    // Shadow of the frame timer: live registers, pending and frame stores
    int unsigned reg_count;
    int unsigned reg_pulse_us;
    int unsigned reg_pause_us;
    logic        reg_invert;
    int unsigned pend_width_us [NCH];
    int unsigned frame_width_us[NCH];
    int unsigned frame_count;
    int unsigned frame_pulse_us;
    int unsigned frame_pause_us;
    int unsigned slot_pos;
    int unsigned ticks_left;

    t_ppm_beat            beat_q[$];
    ppmfg_pkg::t_result   expected_pin_q[$];
    t_ppm_beat            beat_on_bus;
    ppmfg_pkg::t_result   pin_want;
    int                   beats_outstanding = 0;
    int                   mismatch_count    = 0;
    int                   results_seen      = 0;
    int                   burst_left        = 1;
    int                   gap_left          = 0;
    int                   rx_cycle          = 0;
    int                   rx_hold_left      = 0;
    int                   rx_mode_left      = 0;
    t_rx_mode             rx_mode           = RX_STEADY;
    int                   quiet_cycles      = 0;

    // Length in ticks of one interval of the current frame
    function automatic int unsigned slot_ticks(int unsigned p);
        int unsigned pulse_t;
        int unsigned w;
        pulse_t = frame_pulse_us * 2;
        if (p % 2 == 0) begin
            return (pulse_t != 0) ? pulse_t : 1;
        end
        if (p / 2 < frame_count) begin
            w = frame_width_us[p / 2] * 2;
        end else begin
            w = frame_pause_us * 2;
        end
        // short gap collapses to a single tick
        return (w > pulse_t) ? w - pulse_t : 1;
    endfunction

    function automatic void latch_frame();
        for (int i = 0; i < NCH; i++) begin
            frame_width_us[i] = pend_width_us[i];
        end
        if (reg_count < 1) begin
            frame_count = 1;
        end else if (reg_count > NCH) begin
            frame_count = NCH;
        end else begin
            frame_count = reg_count;
        end
        frame_pulse_us = reg_pulse_us;
        frame_pause_us = reg_pause_us;
    endfunction

    function automatic void reset_timer_model();
        reg_count    = 32'(ppmfg_pkg::RESET_COUNT);
        reg_pulse_us = 32'(ppmfg_pkg::RESET_PULSE_US);
        reg_pause_us = 32'(ppmfg_pkg::RESET_PAUSE_US);
        reg_invert   = 1'b0;
        for (int i = 0; i < NCH; i++) begin
            pend_width_us[i] = 32'(ppmfg_pkg::RESET_WIDTH_US);
        end
        latch_frame();
        slot_pos   = 0;
        ticks_left = slot_ticks(0);
    endfunction

    function automatic void apply_reg(logic [ppmfg_pkg::CFG_ADDR_W-1:0] addr,
                                      logic [ppmfg_pkg::WIDTH_W-1:0] data);
        case (addr)
            ppmfg_pkg::REG_CHANNEL_COUNT: reg_count = 32'(data[ppmfg_pkg::COUNT_W-1:0]);
            ppmfg_pkg::REG_PULSE_LENGTH:  reg_pulse_us = 32'(data);
            ppmfg_pkg::REG_PAUSE_LENGTH:  reg_pause_us = 32'(data);
            ppmfg_pkg::REG_INVERT:        reg_invert   = data[0];
            default: ;
        endcase
    endfunction

    // Advance the timer by one beat and return the pin state it leaves
    function automatic ppmfg_pkg::t_result step_ppm_timer(t_ppm_beat b);
        ppmfg_pkg::t_result r;
        r.frame_start = 1'b0;
        if (b.action == ppmfg_pkg::ACT_WRITE) begin
            if (int'(b.idx) < NCH) begin
                pend_width_us[b.idx] = 32'(b.width_us);
            end
        end else if (ticks_left > 1) begin
            ticks_left--;
        end else begin
            slot_pos++;
            if (slot_pos >= 2 * (frame_count + 1)) begin
                slot_pos = 0;
                latch_frame();
                r.frame_start = 1'b1;
            end
            ticks_left = slot_ticks(slot_pos);
        end
        r.level = logic'(slot_pos % 2 == 0) ^ reg_invert;
        return r;
    endfunction

    function automatic void push_beat(logic act, int unsigned idx, int unsigned w);
        t_ppm_beat b;
        b.action   = act;
        b.idx      = idx[ppmfg_pkg::CHAN_IDX_W-1:0];
        b.width_us = w[ppmfg_pkg::WIDTH_W-1:0];
        beat_q.push_back(b);
        beats_outstanding++;
    endfunction

    // Mostly short widths; a rare full-range value is overwritten at once
    function automatic void push_random_write();
        int unsigned idx;
        idx = $urandom_range(0, NCH - 1);
        if ($urandom_range(0, 99) == 0) begin
            push_beat(ppmfg_pkg::ACT_WRITE, idx, $urandom_range(0, FULL_W_MAX));
        end
        push_beat(ppmfg_pkg::ACT_WRITE, idx, $urandom_range(0, SMALL_W_MAX));
    endfunction

    task automatic wait_drained();
        while (beats_outstanding != 0 || expected_pin_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ppmfg_pkg::CFG_ADDR_W-1:0] addr, int unsigned data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data[ppmfg_pkg::WIDTH_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_reg(addr, data[ppmfg_pkg::WIDTH_W-1:0]);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int unsigned cnt, int unsigned pulse, int unsigned pause,
                             logic inv, int n_beats);
        wait_drained();
        write_reg(ppmfg_pkg::REG_CHANNEL_COUNT, cnt);
        write_reg(ppmfg_pkg::REG_PULSE_LENGTH, pulse);
        write_reg(ppmfg_pkg::REG_PAUSE_LENGTH, pause);
        write_reg(ppmfg_pkg::REG_INVERT, 32'(inv));
        repeat (n_beats) begin
            if ($urandom_range(0, 99) < 15) begin
                push_random_write();
            end else begin
                push_beat(ppmfg_pkg::ACT_TICK, $urandom, $urandom);
            end
        end
    endtask

    // Clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Stimulus
    initial begin
        reset_timer_model();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset timing, both beat kinds, field extremes
        push_beat(ppmfg_pkg::ACT_TICK, 0, 0);
        push_beat(ppmfg_pkg::ACT_TICK, NCH - 1, FULL_W_MAX);
        push_beat(ppmfg_pkg::ACT_WRITE, 0, 0);
        push_beat(ppmfg_pkg::ACT_WRITE, NCH - 1, FULL_W_MAX);
        push_beat(ppmfg_pkg::ACT_TICK, 0, 0);
        push_beat(ppmfg_pkg::ACT_WRITE, 10, 32'h5555);
        push_beat(ppmfg_pkg::ACT_WRITE, 5, 32'h2AAA);
        push_beat(ppmfg_pkg::ACT_TICK, 32'hA, 32'h5555);
        push_beat(ppmfg_pkg::ACT_TICK, 32'h5, 32'h2AAA);
        push_beat(ppmfg_pkg::ACT_WRITE, 3, 32'(ppmfg_pkg::RESET_WIDTH_US));
        push_beat(ppmfg_pkg::ACT_WRITE, 0, FULL_W_MAX);
        push_beat(ppmfg_pkg::ACT_WRITE, 0, 1);
        repeat (12) push_beat(ppmfg_pkg::ACT_TICK, $urandom, $urandom);

        // new setup, apart from the invert bit, stays pending while the reset-time frame runs
        run_phase(3, 1, 12, 1'b1, 0);
        for (int i = 0; i < NCH; i++) begin
            push_beat(ppmfg_pkg::ACT_WRITE, i, $urandom_range(0, SMALL_W_MAX));
        end
        repeat (DRAIN_TICKS) begin
            if ($urandom_range(0, 99) == 0) begin
                push_random_write();
            end else begin
                push_beat(ppmfg_pkg::ACT_TICK, $urandom, $urandom);
            end
        end

        // writes to unused register slots must change nothing
        wait_drained();
        for (int a = int'(ppmfg_pkg::REG_INVERT) + 1; a < (1 << ppmfg_pkg::CFG_ADDR_W);
             a++) begin
            write_reg(ppmfg_pkg::CFG_ADDR_W'(a), $urandom);
        end

        // zero pulse and zero pause; count clamps low, high and through the mask
        run_phase(NCH, 0, 0, 1'b0, PHASE_BEATS);
        run_phase(0, 2, 30, 1'b1, PHASE_BEATS);
        run_phase(31, 3, 5, 1'b0, PHASE_BEATS);
        run_phase(32'h7FE5, 1, 7, 1'b1, PHASE_BEATS);
        repeat (4) begin
            run_phase($urandom_range(1, NCH), $urandom_range(0, 4), $urandom_range(0, 40),
                      1'($urandom_range(0, 1)), PHASE_BEATS);
        end

        // near-longest pulse and pause (32766 us) written last, then more ticks
        run_phase(NCH, REG_MAX_US, REG_MAX_US, 1'b1, 0);
        repeat (TAIL_TICKS) push_beat(ppmfg_pkg::ACT_TICK, $urandom, $urandom);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_pin_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Sender: bursts of beats with random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_pin_q.push_back(step_ppm_timer(beat_on_bus));
                beats_outstanding--;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (beat_q.size() != 0) begin
                    beat_on_bus = beat_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= beat_on_bus.action;
                    s_axis_tdata  <= {{S_PAD_W{1'b0}}, beat_on_bus.width_us,
                                      beat_on_bus.idx};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern changes every so often, plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cycle++;
            if (rx_cycle == HOLD_START) begin
                rx_hold_left = HOLD_CYCLES;
            end
            if (rx_mode_left == 0) begin
                case ($urandom_range(0, 2))
                    0:       rx_mode = RX_STEADY;
                    1:       rx_mode = RX_LIGHT;
                    default: rx_mode = RX_HEAVY;
                endcase
                rx_mode_left = $urandom_range(16, 200);
            end else begin
                rx_mode_left--;
            end
            if (rx_hold_left != 0) begin
                rx_hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_STEADY: m_axis_tready <= 1'b1;
                    RX_LIGHT:  m_axis_tready <= ($urandom_range(0, 3) != 0);
                    default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Check each result beat against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_pin_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("result %0d: unexpected beat tdata=%0h tuser=%0b",
                             results_seen, m_axis_tdata, m_axis_tuser);
                end
            end else begin
                pin_want = expected_pin_q.pop_front();
                if (m_axis_tdata !== {{(ppmfg_pkg::M_TDATA_W - 1){1'b0}}, pin_want.level} ||
                    m_axis_tuser !== pin_want.frame_start) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("result %0d: expected level=%0b start=%0b, %s%0h tuser=%0b",
                                 results_seen, pin_want.level, pin_want.frame_start,
                                 "got tdata=", m_axis_tdata, m_axis_tuser);
                    end
                end
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

endmodule

// ===== ppm_frame_generator.f =====
rtl/ppmfg_pkg.sv
rtl/ppmfg_store.sv
rtl/ppmfg_timer.sv
rtl/ppmfg_out.sv
rtl/ppm_frame_generator.sv
sim/tb_top.sv
